// ===== src/hps_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hps_pkg
// Shared transaction types and operation codes of the HRRN scheduler.
// ----------------------------------------------------------------------------
package hps_pkg;

	localparam logic OP_TICK   = 1'b0;
	localparam logic OP_ARRIVE = 1'b1;

	typedef struct packed {
		logic        operation;
		logic [7:0]  job_id;
		logic [31:0] arrival_time;
		logic [15:0] service_time;
	} req_item_t;

	typedef struct packed {
		logic        running_valid;
		logic [7:0]  running_job;
		logic [15:0] remaining_ticks;
		logic        table_full;
		logic [4:0]  ready_count;
	} rsp_item_t;

endpackage

// ===== src/hps_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hps_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module hps_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ===== src/hps_ratio_cmp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hps_ratio_cmp
// Exact response ratio compare by cross-multiplication, products registered.
// ----------------------------------------------------------------------------
module hps_ratio_cmp #(
	parameter int TIME_BITS    = 32,
	parameter int SERVICE_BITS = 16
) (
	input  logic                    clk,
	input  logic                    load,
	input  logic [TIME_BITS-1:0]    now,
	input  logic [TIME_BITS-1:0]    cand_arr,
	input  logic [SERVICE_BITS-1:0] cand_srv,
	input  logic [TIME_BITS-1:0]    best_arr,
	input  logic [SERVICE_BITS-1:0] best_srv,
	output logic                    beats
);

	// W + S needs room for the larger of the two operands plus sign and carry
	localparam int MW = ((TIME_BITS > SERVICE_BITS) ? TIME_BITS : SERVICE_BITS) + 2;
	localparam int PW = MW + SERVICE_BITS + 1;

	logic signed [MW-1:0] ws_c;
	logic signed [MW-1:0] ws_b;
	logic signed [PW-1:0] ws_c_x;
	logic signed [PW-1:0] ws_b_x;
	logic signed [PW-1:0] srv_c_x;
	logic signed [PW-1:0] srv_b_x;
	logic signed [PW-1:0] prod_c_q;
	logic signed [PW-1:0] prod_b_q;
	logic                 zc_q;
	logic                 zb_q;
	logic                 arr_lt_q;

	always_comb begin
		ws_c = $signed(MW'(now)) - $signed(MW'(cand_arr)) - $signed(MW'(1))
			+ $signed(MW'(cand_srv));
		ws_b = $signed(MW'(now)) - $signed(MW'(best_arr)) - $signed(MW'(1))
			+ $signed(MW'(best_srv));
		ws_c_x  = PW'(ws_c);
		ws_b_x  = PW'(ws_b);
		srv_c_x = $signed(PW'(cand_srv));
		srv_b_x = $signed(PW'(best_srv));
	end

	always_ff @(posedge clk) begin
		if (load) begin
			prod_c_q <= ws_c_x * srv_b_x;
			prod_b_q <= ws_b_x * srv_c_x;
			zc_q     <= (cand_srv == '0);
			zb_q     <= (best_srv == '0);
			arr_lt_q <= (cand_arr < best_arr);
		end
	end

	// zero service ranks above every finite ratio; ties fall to earlier arrival
	always_comb begin
		if (zc_q || zb_q) begin
			if (!zc_q) begin
				beats = 1'b0;
			end else if (!zb_q) begin
				beats = 1'b1;
			end else begin
				beats = arr_lt_q;
			end
		end else if (prod_c_q != prod_b_q) begin
			beats = (prod_c_q > prod_b_q);
		end else begin
			beats = arr_lt_q;
		end
	end

endmodule

// ===== src/hrrn_process_scheduler.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hrrn_process_scheduler
// Non-preemptive highest-response-ratio-next job scheduler.
// ----------------------------------------------------------------------------
// Request channel (req_valid/req_ready/req): an arrive transaction stores a job
// in the lowest free slot of the ready table (table_full flags a drop); a tick
// transaction advances the clock and, when no job runs or the running job is
// done, starts the ready job with the highest response ratio.
// Response channel (rsp_valid/rsp_ready/rsp): one transaction per request,
// reporting the running job, its remaining ticks, the drop flag and the count.
// Flow: arrive, and tick without a pick, go from accept via S_OUT to response.
// A tick that picks scans the table held in RAM: S_RD alone per empty slot,
// S_RD (RAM read), S_MUL (registered cross-products), S_CMP (compare) per
// occupied slot, then S_PICK and S_OUT. One request at a time.
// The next request is accepted while a response still waits on rsp_ready; a
// stalled response holds, and the following response waits behind it.
// Reset clears the valid bits, the running job and the clock at once; the
// table RAM needs no clearing pass.
// ----------------------------------------------------------------------------
module hrrn_process_scheduler #(
	parameter int TABLE_DEPTH  = 16,
	parameter int TIME_BITS    = 32,
	parameter int SERVICE_BITS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               req_valid,
	output logic               req_ready,
	input  hps_pkg::req_item_t req,
	output logic               rsp_valid,
	input  logic               rsp_ready,
	output hps_pkg::rsp_item_t rsp
);

	localparam int AW = $clog2(TABLE_DEPTH);
	localparam int CW = $clog2(TABLE_DEPTH + 1);
	localparam int RW = 8 + TIME_BITS + SERVICE_BITS;

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_RD   = 3'd1;
	localparam logic [2:0] S_MUL  = 3'd2;
	localparam logic [2:0] S_CMP  = 3'd3;
	localparam logic [2:0] S_PICK = 3'd4;
	localparam logic [2:0] S_OUT  = 3'd5;

	logic [2:0]              state_q;
	logic [TABLE_DEPTH-1:0]  valid_q;
	logic [CW-1:0]           count_q;
	logic [TIME_BITS-1:0]    now_q;
	logic                    run_active_q;
	logic [7:0]              run_job_q;
	logic [SERVICE_BITS-1:0] run_left_q;
	logic                    full_q;
	logic [AW-1:0]           idx_q;
	logic                    found_q;
	logic [AW-1:0]           best_slot_q;
	logic [7:0]              best_job_q;
	logic [TIME_BITS-1:0]    best_arr_q;
	logic [SERVICE_BITS-1:0] best_srv_q;
	logic                    rsp_valid_q;
	hps_pkg::rsp_item_t      rsp_q;

	logic                    accept;
	logic                    free_found;
	logic [AW-1:0]           free_idx;
	logic                    idx_last;
	logic [AW-1:0]           idx_next;
	logic                    ram_we;
	logic                    ram_re;
	logic [RW-1:0]           ram_wdata;
	logic [RW-1:0]           ram_rdata;
	logic [7:0]              rd_job;
	logic [TIME_BITS-1:0]    rd_arr;
	logic [SERVICE_BITS-1:0] rd_srv;
	logic                    cmp_beats;
	logic                    rsp_free;

	assign req_ready = (state_q == S_IDLE);
	assign accept    = req_valid && req_ready;
	assign rsp_free  = !rsp_valid_q || rsp_ready;
	assign idx_last  = (idx_q == AW'(TABLE_DEPTH - 1));
	assign idx_next  = AW'(idx_q + 1'b1);

	// lowest free slot
	always_comb begin
		free_found = 1'b0;
		free_idx   = '0;
		for (int i = TABLE_DEPTH - 1; i >= 0; i--) begin
			if (!valid_q[i]) begin
				free_found = 1'b1;
				free_idx   = AW'(i);
			end
		end
	end

	assign ram_we    = accept && (req.operation == hps_pkg::OP_ARRIVE) && free_found;
	assign ram_wdata = {req.job_id, TIME_BITS'(req.arrival_time),
		SERVICE_BITS'(req.service_time)};
	assign ram_re    = (state_q == S_RD) && valid_q[idx_q];

	assign rd_job = ram_rdata[RW-1 -: 8];
	assign rd_arr = ram_rdata[SERVICE_BITS +: TIME_BITS];
	assign rd_srv = ram_rdata[SERVICE_BITS-1:0];

	hps_ram #(
		.WIDTH (RW),
		.DEPTH (TABLE_DEPTH)
	) u_table (
		.clk   (clk),
		.we    (ram_we),
		.waddr (free_idx),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (idx_q),
		.rdata (ram_rdata)
	);

	hps_ratio_cmp #(
		.TIME_BITS    (TIME_BITS),
		.SERVICE_BITS (SERVICE_BITS)
	) u_cmp (
		.clk      (clk),
		.load     (state_q == S_MUL),
		.now      (now_q),
		.cand_arr (rd_arr),
		.cand_srv (rd_srv),
		.best_arr (best_arr_q),
		.best_srv (best_srv_q),
		.beats    (cmp_beats)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			valid_q      <= '0;
			count_q      <= '0;
			now_q        <= '0;
			run_active_q <= 1'b0;
			run_job_q    <= '0;
			run_left_q   <= '0;
			full_q       <= 1'b0;
			idx_q        <= '0;
			found_q      <= 1'b0;
			rsp_valid_q  <= 1'b0;
		end else begin
			if (state_q == S_OUT && rsp_free) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_valid_q && rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (req.operation == hps_pkg::OP_ARRIVE) begin
							full_q <= !free_found;
							if (free_found) begin
								valid_q[free_idx] <= 1'b1;
								count_q           <= CW'(count_q + 1'b1);
							end
							state_q <= S_OUT;
						end else begin
							full_q <= 1'b0;
							now_q  <= TIME_BITS'(now_q + 1'b1);
							if (!run_active_q || run_left_q == '0) begin
								idx_q   <= '0;
								found_q <= 1'b0;
								state_q <= S_RD;
							end else begin
								run_left_q <= SERVICE_BITS'(run_left_q - 1'b1);
								state_q    <= S_OUT;
							end
						end
					end
				end
				S_RD: begin
					if (valid_q[idx_q]) begin
						state_q <= S_MUL;
					end else if (idx_last) begin
						state_q <= S_PICK;
					end else begin
						idx_q <= idx_next;
					end
				end
				S_MUL: begin
					state_q <= S_CMP;
				end
				S_CMP: begin
					if (!found_q || cmp_beats) begin
						found_q     <= 1'b1;
						best_slot_q <= idx_q;
					end
					if (idx_last) begin
						state_q <= S_PICK;
					end else begin
						idx_q   <= idx_next;
						state_q <= S_RD;
					end
				end
				S_PICK: begin
					if (found_q) begin
						valid_q[best_slot_q] <= 1'b0;
						count_q              <= CW'(count_q - 1'b1);
						run_active_q         <= 1'b1;
						run_job_q            <= best_job_q;
						// the first tick of the new job is spent right away
						run_left_q           <= (best_srv_q == '0) ? '0
							: SERVICE_BITS'(best_srv_q - 1'b1);
					end else begin
						run_active_q <= 1'b0;
						run_job_q    <= '0;
						run_left_q   <= '0;
					end
					state_q <= S_OUT;
				end
				S_OUT: begin
					if (rsp_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// best-so-far payload, no reset needed
	always_ff @(posedge clk) begin
		if (state_q == S_CMP && (!found_q || cmp_beats)) begin
			best_job_q <= rd_job;
			best_arr_q <= rd_arr;
			best_srv_q <= rd_srv;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_OUT && rsp_free) begin
			rsp_q.running_valid   <= run_active_q;
			rsp_q.running_job     <= run_job_q;
			rsp_q.remaining_ticks <= 16'(run_left_q);
			rsp_q.table_full      <= full_q;
			rsp_q.ready_count     <= 5'(count_q);
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	a_count_matches: assert property (@(posedge clk) disable iff (!arst_n)
		count_q == CW'($countones(valid_q)))
		else $error("ready count out of step with valid bits");

	a_idle_clean: assert property (@(posedge clk) disable iff (!arst_n)
		!run_active_q |-> (run_job_q == '0 && run_left_q == '0))
		else $error("idle scheduler holds stale job state");

	a_pick_valid: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_PICK && found_q) |-> valid_q[best_slot_q])
		else $error("picked slot is not occupied");

	a_rsp_after_out: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid_q) |-> $past(state_q) == S_OUT)
		else $error("response raised outside of output state");

endmodule
